[rtl/dhfk_pkg.sv]
package dhfk_pkg;

	// CORDIC datapath: Q30 x/y and 32-bit-circle angle, with headroom
	typedef logic signed [33:0] cw_t;
	// sine/cosine in signed Q4.14
	typedef logic signed [17:0] trig_t;
	// link matrix entry, Q10.16
	typedef logic signed [25:0] ent_t;
	typedef logic signed [51:0] prod_t;
	typedef logic signed [31:0] col_t;
	typedef ent_t [3:0][3:0] mat_t;
	typedef col_t [3:0] row_t;
	typedef row_t [2:0] rows_t;

	typedef struct packed {
		cw_t x;
		cw_t y;
		cw_t z;
	} rot_t;

	typedef enum logic [2:0] {
		REG_LENGTH_ONE = 3'd0,
		REG_LENGTH_TWO = 3'd1,
		REG_TWIST_ONE  = 3'd2,
		REG_TWIST_TWO  = 3'd3,
		REG_OFFSET_ONE = 3'd4,
		REG_OFFSET_TWO = 3'd5
	} reg_idx_t;

	localparam int NUM_REGS = 6;
	localparam int CORDIC_STEPS = 16;
	localparam int STEPS_PER_STAGE = 4;
	localparam int LAST_ROW = 3;
	localparam cw_t CORDIC_GAIN = 34'sd652032874;
	localparam col_t ONE_Q16 = 32'sd65536;

	localparam cw_t ATAN [CORDIC_STEPS] = '{
		34'sd536870912, 34'sd316933406, 34'sd167458907, 34'sd85004756,
		34'sd42667331, 34'sd21354465, 34'sd10679838, 34'sd5340245,
		34'sd2670163, 34'sd1335087, 34'sd667544, 34'sd333772,
		34'sd166886, 34'sd83443, 34'sd41722, 34'sd20861
	};

	// four micro-rotations starting at iteration base
	function automatic rot_t cordic_step4(rot_t r, int base);
		rot_t o;
		cw_t t;
		int i;
		o = r;
		for (int k = 0; k < STEPS_PER_STAGE; k++) begin
			i = base + k;
			if (!o.z[33]) begin
				t = o.x - (o.y >>> i);
				o.y = o.y + (o.x >>> i);
				o.z = o.z - ATAN[i];
			end else begin
				t = o.x + (o.y >>> i);
				o.y = o.y - (o.x >>> i);
				o.z = o.z + ATAN[i];
			end
			o.x = t;
		end
		return o;
	endfunction

	// round half up, then drop n fraction bits
	function automatic ent_t round_ent(logic signed [36:0] v, int n);
		logic signed [36:0] s;
		s = (v + (37'sd1 <<< (n - 1))) >>> n;
		return ent_t'(s);
	endfunction

endpackage

[rtl/dhfk_joint_if.sv]
interface dhfk_joint_if;
	logic valid;
	logic ready;
	logic signed [15:0] joint_angle_one;
	logic signed [15:0] joint_angle_two;

	modport source (output valid, output joint_angle_one, output joint_angle_two, input ready);
	modport sink (input valid, input joint_angle_one, input joint_angle_two, output ready);
endinterface

[rtl/dhfk_row_if.sv]
interface dhfk_row_if;
	logic valid;
	logic ready;
	logic [1:0] row_index;
	logic signed [31:0] column_zero;
	logic signed [31:0] column_one;
	logic signed [31:0] column_two;
	logic signed [31:0] column_three;
	logic last_row;

	modport source (output valid, output row_index, output column_zero, output column_one,
		output column_two, output column_three, output last_row, input ready);
	modport sink (input valid, input row_index, input column_zero, input column_one,
		input column_two, input column_three, input last_row, output ready);
endinterface

[rtl/dh_two_link_forward_kinematics.sv]
// Two-link Denavit-Hartenberg forward kinematics. Each transfer on joints carries
// two 16-bit binary joint angles; the block answers with four transfers on rows,
// the rows 0..3 of the 4x4 homogeneous transform in signed Q16.16, row 3 being
// 0,0,0,1 and flagged by last_row. Link lengths, twists and offsets sit in six
// 16-bit registers written over the plain write port (index 0..5, others dropped),
// to be changed only while the block is idle. Sines and cosines come from a
// 16-iteration CORDIC, four iterations per stage. The pipeline takes a new item
// every cycle while it is not stalled, but the single row port drains four rows
// per item, so the row serializer sets the sustained rate; the whole pipeline
// stalls while a finished item waits for the serializer.
module dh_two_link_forward_kinematics (
	input  logic                clk,
	input  logic                arst_n,
	dhfk_joint_if.sink          joints,
	dhfk_row_if.source          rows,
	input  logic                write_enable,
	input  logic [2:0]          reg_index,
	input  logic [15:0]         write_data
);
	import dhfk_pkg::*;

	logic signed [15:0] cfg_q [NUM_REGS];
	logic [9:1] stage_valid_q;
	logic       busy_q;
	logic [1:0] row_q;
	rows_t      rows_q;
	logic       adv;

	trig_t st1, ct1, sa1, ca1, st2, ct2, sa2, ca2;
	mat_t  m1, m2;
	rows_t prod_rows;

	// advance the whole pipe unless a finished item has nowhere to go
	assign adv = !stage_valid_q[9] || !busy_q || (rows.ready && row_q == 2'(LAST_ROW));
	assign joints.ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_REGS; i++) cfg_q[i] <= '0;
		end else if (write_enable && reg_index < 3'(NUM_REGS)) begin
			cfg_q[reg_index] <= write_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_valid_q <= '0;
		end else if (adv) begin
			stage_valid_q <= {stage_valid_q[8:1], joints.valid};
		end
	end

	dhfk_sincos u_theta_one (.clk, .en(adv), .angle(joints.joint_angle_one),
		.sin_val(st1), .cos_val(ct1));
	dhfk_sincos u_alpha_one (.clk, .en(adv), .angle(cfg_q[REG_TWIST_ONE]),
		.sin_val(sa1), .cos_val(ca1));
	dhfk_sincos u_theta_two (.clk, .en(adv), .angle(joints.joint_angle_two),
		.sin_val(st2), .cos_val(ct2));
	dhfk_sincos u_alpha_two (.clk, .en(adv), .angle(cfg_q[REG_TWIST_TWO]),
		.sin_val(sa2), .cos_val(ca2));

	dhfk_link u_link_one (.clk, .en(adv), .st(st1), .ct(ct1), .sa(sa1), .ca(ca1),
		.len(cfg_q[REG_LENGTH_ONE]), .offs(cfg_q[REG_OFFSET_ONE]), .mat(m1));
	dhfk_link u_link_two (.clk, .en(adv), .st(st2), .ct(ct2), .sa(sa2), .ca(ca2),
		.len(cfg_q[REG_LENGTH_TWO]), .offs(cfg_q[REG_OFFSET_TWO]), .mat(m2));

	dhfk_matmul u_matmul (.clk, .en(adv), .m1, .m2, .rows(prod_rows));

	// row serializer: load a finished item, then step one row per transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			row_q  <= '0;
		end else if (adv && stage_valid_q[9]) begin
			busy_q <= 1'b1;
			row_q  <= '0;
		end else if (busy_q && rows.ready) begin
			if (row_q == 2'(LAST_ROW)) busy_q <= 1'b0;
			row_q <= row_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && stage_valid_q[9]) rows_q <= prod_rows;
	end

	assign rows.valid     = busy_q;
	assign rows.row_index = row_q;
	assign rows.last_row  = (row_q == 2'(LAST_ROW));

	always_comb begin
		case (row_q)
			2'd0: begin
				rows.column_zero  = rows_q[0][0];
				rows.column_one   = rows_q[0][1];
				rows.column_two   = rows_q[0][2];
				rows.column_three = rows_q[0][3];
			end
			2'd1: begin
				rows.column_zero  = rows_q[1][0];
				rows.column_one   = rows_q[1][1];
				rows.column_two   = rows_q[1][2];
				rows.column_three = rows_q[1][3];
			end
			2'd2: begin
				rows.column_zero  = rows_q[2][0];
				rows.column_one   = rows_q[2][1];
				rows.column_two   = rows_q[2][2];
				rows.column_three = rows_q[2][3];
			end
			default: begin
				// constant bottom row of a homogeneous transform
				rows.column_zero  = '0;
				rows.column_one   = '0;
				rows.column_two   = '0;
				rows.column_three = ONE_Q16;
			end
		endcase
	end
endmodule

[rtl/dhfk_sincos.sv]
module dhfk_sincos (
	input  logic               clk,
	input  logic               en,
	input  logic signed [15:0] angle,
	output dhfk_pkg::trig_t    sin_val,
	output dhfk_pkg::trig_t    cos_val
);
	import dhfk_pkg::*;

	logic signed [16:0] ang_ext, fold;
	logic               flip;
	rot_t r_s1, r_s2, r_s3, r_s4, r_s5;
	logic flip_s1, flip_s2, flip_s3, flip_s4, flip_s5;
	trig_t sin_s6, cos_s6;
	cw_t xr, yr;

	// fold into [-pi/2, pi/2]
	always_comb begin
		ang_ext = {angle[15], angle};
		flip = 1'b0;
		fold = ang_ext;
		if (ang_ext > 17'sd16384) begin
			fold = ang_ext - 17'sd32768;
			flip = 1'b1;
		end else if (ang_ext < -17'sd16384) begin
			fold = ang_ext + 17'sd32768;
			flip = 1'b1;
		end
	end

	assign xr = (r_s5.x + 34'sd32768) >>> 16;
	assign yr = (r_s5.y + 34'sd32768) >>> 16;

	always_ff @(posedge clk) begin
		if (en) begin
			r_s1.x  <= CORDIC_GAIN;
			r_s1.y  <= '0;
			r_s1.z  <= cw_t'({fold[16], fold, 16'b0});
			flip_s1 <= flip;
			r_s2    <= cordic_step4(r_s1, 0);
			flip_s2 <= flip_s1;
			r_s3    <= cordic_step4(r_s2, 4);
			flip_s3 <= flip_s2;
			r_s4    <= cordic_step4(r_s3, 8);
			flip_s4 <= flip_s3;
			r_s5    <= cordic_step4(r_s4, 12);
			flip_s5 <= flip_s4;
			cos_s6  <= flip_s5 ? -trig_t'(xr) : trig_t'(xr);
			sin_s6  <= flip_s5 ? -trig_t'(yr) : trig_t'(yr);
		end
	end

	assign sin_val = sin_s6;
	assign cos_val = cos_s6;
endmodule

[rtl/dhfk_link.sv]
module dhfk_link (
	input  logic               clk,
	input  logic               en,
	input  dhfk_pkg::trig_t    st,
	input  dhfk_pkg::trig_t    ct,
	input  dhfk_pkg::trig_t    sa,
	input  dhfk_pkg::trig_t    ca,
	input  logic signed [15:0] len,
	input  logic signed [15:0] offs,
	output dhfk_pkg::mat_t     mat
);
	import dhfk_pkg::*;

	logic signed [36:0] p_sc, p_ss, p_cc, p_cs, p_ac, p_as;
	mat_t m_s7;

	always_comb begin
		p_sc = 37'(st * ca);
		p_ss = 37'(st * sa);
		p_cc = 37'(ct * ca);
		p_cs = 37'(ct * sa);
		p_ac = 37'(len * ct);
		p_as = 37'(len * st);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_s7[0][0] <= ent_t'($signed({ct, 2'b00}));
			m_s7[0][1] <= round_ent(-p_sc, 12);
			m_s7[0][2] <= round_ent(p_ss, 12);
			m_s7[0][3] <= round_ent(p_ac, 6);
			m_s7[1][0] <= ent_t'($signed({st, 2'b00}));
			m_s7[1][1] <= round_ent(p_cc, 12);
			m_s7[1][2] <= round_ent(-p_cs, 12);
			m_s7[1][3] <= round_ent(p_as, 6);
			m_s7[2][0] <= '0;
			m_s7[2][1] <= ent_t'($signed({sa, 2'b00}));
			m_s7[2][2] <= ent_t'($signed({ca, 2'b00}));
			m_s7[2][3] <= ent_t'($signed({offs, 8'b0}));
			m_s7[3][0] <= '0;
			m_s7[3][1] <= '0;
			m_s7[3][2] <= '0;
			m_s7[3][3] <= ent_t'(ONE_Q16);
		end
	end

	assign mat = m_s7;
endmodule

[rtl/dhfk_matmul.sv]
module dhfk_matmul (
	input  logic            clk,
	input  logic            en,
	input  dhfk_pkg::mat_t  m1,
	input  dhfk_pkg::mat_t  m2,
	output dhfk_pkg::rows_t rows
);
	import dhfk_pkg::*;

	prod_t prod_s8 [3][4][4];
	rows_t rows_s9;
	logic signed [53:0] acc [3][4];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 4; j++) begin
				acc[i][j] = 54'sd32768;
				for (int k = 0; k < 4; k++) begin
					acc[i][j] = acc[i][j] + 54'(prod_s8[i][j][k]);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 4; j++) begin
					for (int k = 0; k < 4; k++) begin
						prod_s8[i][j][k] <= prod_t'($signed(m1[i][k]) * $signed(m2[k][j]));
					end
					rows_s9[i][j] <= col_t'(acc[i][j] >>> 16);
				end
			end
		end
	end

	assign rows = rows_s9;
endmodule

[verif/tb_dh_two_link_forward_kinematics.sv]
`timescale 1ns / 100ps

module tb_dh_two_link_forward_kinematics;
	import dhfk_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 24;
	localparam int RANDOM_PER_PHASE = 30;
	// indexes past the register file; the block drops such writes
	localparam logic [2:0] REG_SPARE = 3'd6;
	localparam logic [2:0] REG_NONE = 3'd7;

	typedef longint lmat_t [4][4];

	typedef struct {
		logic [1:0]         row_index;
		logic signed [31:0] c0;
		logic signed [31:0] c1;
		logic signed [31:0] c2;
		logic signed [31:0] c3;
		logic               last_row;
	} row_word_t;

	typedef struct {
		logic signed [15:0] theta_one;
		logic signed [15:0] theta_two;
	} angle_pair_t;

	logic clk;
	logic arst_n;
	logic write_enable;
	logic [2:0] reg_index;
	logic [15:0] write_data;

	dhfk_joint_if joints ();
	dhfk_row_if rows ();

	dh_two_link_forward_kinematics dut (
		.clk(clk),
		.arst_n(arst_n),
		.joints(joints.sink),
		.rows(rows.source),
		.write_enable(write_enable),
		.reg_index(reg_index),
		.write_data(write_data)
	);

	// shadow copy of the six link registers
	logic signed [15:0] link_regs [NUM_REGS];
	row_word_t pending_rows [$];
	int errors;
	int rows_seen;
	int pairs_sent;
	int cycles;
	int send_idle_pct;
	int recv_stall_pct;

	// directed angle pairs: zeros, quadrant edges, fold points, extremes
	angle_pair_t angle_table [] = '{
		'{16'sd0, 16'sd0},
		'{16'sd16384, 16'sd0},
		'{16'sd16385, 16'sd16384},
		'{-16'sd16384, -16'sd16385},
		'{-16'sd32768, 16'sd32767},
		'{16'sd32767, -16'sd32768},
		'{-16'sd32768, -16'sd32768},
		'{16'sd32767, 16'sd32767},
		'{16'sd8192, -16'sd8192},
		'{16'sd1, -16'sd1},
		'{16'sd21845, -16'sd10923},
		'{-16'sd1, 16'sd1},
		'{16'h5555, 16'shAAAA},
		'{16'shAAAA, 16'h5555}
	};

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic longint rnd_shift(longint v, int n);
		return (v + (64'sd1 <<< (n - 1))) >>> n;
	endfunction

	// CORDIC sine/cosine to Q2.14 after folding into [-pi/2, pi/2]
	function automatic void sine_cosine(int ang, output longint s, output longint c);
		longint x, y, z, t;
		bit flip;
		x = CORDIC_GAIN;
		y = 0;
		flip = 1'b0;
		if (ang > 16384) begin
			ang -= 32768;
			flip = 1'b1;
		end else if (ang < -16384) begin
			ang += 32768;
			flip = 1'b1;
		end
		z = longint'(ang) * 65536;
		for (int i = 0; i < CORDIC_STEPS; i++) begin
			if (z >= 0) begin
				t = x - (y >>> i);
				y = y + (x >>> i);
				z -= ATAN[i];
			end else begin
				t = x + (y >>> i);
				y = y - (x >>> i);
				z += ATAN[i];
			end
			x = t;
		end
		x = rnd_shift(x, 16);
		y = rnd_shift(y, 16);
		c = flip ? -x : x;
		s = flip ? -y : y;
	endfunction

	function automatic lmat_t dh_link(int theta, int alpha, int a, int d);
		lmat_t m;
		longint st, ct, sa, ca;
		sine_cosine(theta, st, ct);
		sine_cosine(alpha, sa, ca);
		m[0] = '{ct * 4, rnd_shift(-(st * ca), 12), rnd_shift(st * sa, 12),
			rnd_shift(longint'(a) * ct, 6)};
		m[1] = '{st * 4, rnd_shift(ct * ca, 12), rnd_shift(-(ct * sa), 12),
			rnd_shift(longint'(a) * st, 6)};
		m[2] = '{0, sa * 4, ca * 4, longint'(d) * 256};
		m[3] = '{0, 0, 0, 65536};
		return m;
	endfunction

	// queue the four rows of link one times link two
	function automatic void predict_transform(logic signed [15:0] th1, logic signed [15:0] th2);
		lmat_t m1, m2;
		longint acc [4];
		row_word_t w;
		m1 = dh_link(th1, link_regs[REG_TWIST_ONE], link_regs[REG_LENGTH_ONE],
			link_regs[REG_OFFSET_ONE]);
		m2 = dh_link(th2, link_regs[REG_TWIST_TWO], link_regs[REG_LENGTH_TWO],
			link_regs[REG_OFFSET_TWO]);
		for (int i = 0; i < 4; i++) begin
			for (int j = 0; j < 4; j++) begin
				if (i == LAST_ROW) begin
					acc[j] = (j == 3) ? longint'(ONE_Q16) : 0;
				end else begin
					acc[j] = 0;
					for (int k = 0; k < 4; k++)
						acc[j] += m1[i][k] * m2[k][j];
					acc[j] = rnd_shift(acc[j], 16);
				end
			end
			w.row_index = i[1:0];
			w.c0 = acc[0][31:0];
			w.c1 = acc[1][31:0];
			w.c2 = acc[2][31:0];
			w.c3 = acc[3][31:0];
			w.last_row = (i == LAST_ROW);
			pending_rows.push_back(w);
		end
	endfunction

	// check every row transfer against the oldest queued row
	always @(posedge clk) begin
		row_word_t exp_row;
		if (arst_n && rows.valid && rows.ready) begin
			rows_seen++;
			if (pending_rows.size() == 0) begin
				errors++;
				$display("%0t: unexpected row %0d: %h %h %h %h last %b", $time,
					rows.row_index, rows.column_zero, rows.column_one,
					rows.column_two, rows.column_three, rows.last_row);
			end else begin
				exp_row = pending_rows.pop_front();
				if (rows.row_index !== exp_row.row_index || rows.column_zero !== exp_row.c0 ||
					rows.column_one !== exp_row.c1 || rows.column_two !== exp_row.c2 ||
					rows.column_three !== exp_row.c3 || rows.last_row !== exp_row.last_row) begin
					errors++;
					$display("%0t: row mismatch expected %0d: %h %h %h %h last %b", $time,
						exp_row.row_index, exp_row.c0, exp_row.c1, exp_row.c2,
						exp_row.c3, exp_row.last_row);
					$display("%0t:              actual   %0d: %h %h %h %h last %b", $time,
						rows.row_index, rows.column_zero, rows.column_one,
						rows.column_two, rows.column_three, rows.last_row);
				end
			end
		end
		// stall the receiver at random
		rows.ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d rows outstanding", cycles,
				pending_rows.size());
			$display("*** FAILED ***");
			$finish;
		end
	end

	// one angle-pair transfer; valid stays high into the next item unless it idles
	task automatic send_pair(logic signed [15:0] th1, logic signed [15:0] th2);
		while ($urandom_range(99) < send_idle_pct) begin
			joints.valid <= 1'b0;
			@(posedge clk);
		end
		joints.valid <= 1'b1;
		joints.joint_angle_one <= th1;
		joints.joint_angle_two <= th2;
		do @(posedge clk); while (!joints.ready);
		predict_transform(th1, th2);
		pairs_sent++;
	endtask

	task automatic drop_valid();
		joints.valid <= 1'b0;
		@(posedge clk);
	endtask

	// wait out every queued row, then the pipeline depth
	task automatic drain();
		drop_valid();
		while (pending_rows.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [15:0] val);
		write_enable <= 1'b1;
		reg_index <= idx;
		write_data <= val;
		@(posedge clk);
		if (idx < NUM_REGS)
			link_regs[idx] = val;
		write_enable <= 1'b0;
	endtask

	task automatic load_links(logic [15:0] a1, logic [15:0] a2, logic [15:0] al1,
		logic [15:0] al2, logic [15:0] d1, logic [15:0] d2);
		write_reg(REG_LENGTH_ONE, a1);
		write_reg(REG_LENGTH_TWO, a2);
		write_reg(REG_TWIST_ONE, al1);
		write_reg(REG_TWIST_TWO, al2);
		write_reg(REG_OFFSET_ONE, d1);
		write_reg(REG_OFFSET_TWO, d2);
	endtask

	// favor fold boundaries and extremes now and then, otherwise any angle
	function automatic logic [15:0] pick_angle();
		case ($urandom_range(7))
			0: return 16'd16384 + 16'($urandom_range(2)) - 16'd1;
			1: return -16'sd16384 + 16'($urandom_range(2)) - 16'd1;
			2: return $urandom_range(1) ? 16'h7FFF : 16'h8000;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [15:0] pick_reg_value();
		case ($urandom_range(5))
			0: return $urandom_range(1) ? 16'h7FFF : 16'h8000;
			1: return 16'h0000;
			default: return 16'($urandom);
		endcase
	endfunction

	initial begin
		errors = 0;
		rows_seen = 0;
		pairs_sent = 0;
		cycles = 0;
		send_idle_pct = 31;
		recv_stall_pct = 45;
		arst_n = 1'b0;
		write_enable = 1'b0;
		reg_index = REG_LENGTH_ONE;
		write_data = '0;
		joints.valid = 1'b0;
		joints.joint_angle_one = '0;
		joints.joint_angle_two = '0;
		rows.ready = 1'b0;
		for (int i = 0; i < NUM_REGS; i++)
			link_regs[i] = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// registers at reset value: pure rotations
		send_pair(angle_table[0].theta_one, angle_table[0].theta_two);
		send_pair(angle_table[4].theta_one, angle_table[4].theta_two);
		drain();

		// directed table under a typical arm, then its extreme pairs under all-extreme links
		load_links(16'sd256, 16'sd128, 16'sd16384, -16'sd16384, 16'sd64, -16'sd64);
		foreach (angle_table[n])
			send_pair(angle_table[n].theta_one, angle_table[n].theta_two);
		drain();
		load_links(16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF);
		write_reg(REG_NONE, 16'h1234);
		write_reg(REG_SPARE, 16'hFFFF);
		for (int n = 4; n < 8; n++)
			send_pair(angle_table[n].theta_one, angle_table[n].theta_two);
		drain();

		// random phases: receiver stalls more first, then sender idles more, then neither
		for (int ph = 0; ph < 6; ph++) begin
			if (ph == 2) begin
				send_idle_pct = 45;
				recv_stall_pct = 31;
			end else if (ph == 4) begin
				send_idle_pct = 0;
				recv_stall_pct = 0;
			end
			if (ph == 5)
				load_links(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
			else
				load_links(pick_reg_value(), pick_reg_value(), pick_reg_value(),
					pick_reg_value(), pick_reg_value(), pick_reg_value());
			for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
				// hold off once until the row queue runs dry
				if (ph == 1 && n == 15) begin
					drop_valid();
					while (pending_rows.size() != 0)
						@(posedge clk);
				end
				send_pair(pick_angle(), pick_angle());
			end
			drain();
		end

		$display("%0d angle pairs sent, %0d rows checked across 9 link settings",
			pairs_sent, rows_seen);
		$display("covered reset, extreme and random link registers, ignored indexes, stalls");
		if (errors == 0 && pending_rows.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

[filelist.f]
rtl/dhfk_pkg.sv
rtl/dhfk_joint_if.sv
rtl/dhfk_row_if.sv
rtl/dhfk_sincos.sv
rtl/dhfk_link.sv
rtl/dhfk_matmul.sv
rtl/dh_two_link_forward_kinematics.sv
verif/tb_dh_two_link_forward_kinematics.sv
